FILE: sv/mbs_pkg.sv
// Shared constants and the command type of the marker byte-stuffing encoder.
package mbs_pkg;

  localparam int MAX_PAYLOAD_DEF = 254;
  localparam logic [7:0] MARKER_RESET = 8'd126;
  localparam logic [7:0] NO_MARKER = 8'hFF;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_DIRECT = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic       wflag;
    logic       link_we;
    logic [7:0] link_addr;
    logic [7:0] value;
    logic       is_overhead;
    logic       last;
    logic       last_marker;
  } mbs_cmd_t;

endpackage

FILE: sv/mbs_if.sv
// Valid/ready channel interfaces for input items and encoded results.
interface mbs_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface mbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_overhead;
  logic       last;

  modport source (output valid, output out_byte, output is_overhead, output last,
                  input ready);
  modport sink (input valid, input out_byte, input is_overhead, input last,
                output ready);
endinterface

FILE: sv/marker_byte_stuffing_encoder_core.sv
// Top level of the marker byte-stuffing encoder.
// Input channel in_chan carries beats with opcode (push or pull) and data_byte.
// A push stores a payload byte; a marker byte is stored with a link to the next
// marker so the stuffed form is ready at read-out. Pushes beyond MAX_PAYLOAD
// bytes and pushes during a read-out are dropped without a result.
// Each pull yields one beat on out_chan: first the overhead byte (index of the
// first marker, or 255), then the stuffed payload, the final beat with last set.
// cfg_we/cfg_wdata write the marker value; write it only while the block is idle.
// Throughput: one input beat per cycle while in_chan.ready is high. A pull's
// result passes the command queue, the read stage and the output register in
// turn: the edge that pops it from the queue also reads the payload memory.
// When out_chan stalls, the read stage and the two-entry command queue fill
// and in_chan.ready drops; pushes keep flowing until the queue is full.
// Reset (rst_n low, synchronous) empties the store, clears the queue and the
// output register and restores the marker value to 126. Stored bytes are not
// cleared; no clearing pass is needed.
module marker_byte_stuffing_encoder_core #(
  parameter int MAX_PAYLOAD = mbs_pkg::MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  mbs_in_if.sink     in_chan,
  mbs_out_if.source  out_chan
);

  logic              cmd_valid;
  mbs_pkg::mbs_cmd_t cmd;
  logic              q_full;
  logic              pop;
  logic              head_valid;
  mbs_pkg::mbs_cmd_t head_cmd;

  mbs_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .q_full   (q_full)
  );

  mbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_valid),
    .push_cmd  (cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  mbs_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule

FILE: sv/mbs_front.sv
// Front end: accepts items, tracks packet bookkeeping and issues back-end commands.
module mbs_front #(
  parameter int MAX_PAYLOAD = mbs_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  mbs_in_if.sink           in_chan,
  output logic             cmd_valid,
  output mbs_pkg::mbs_cmd_t cmd,
  input  logic             q_full
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]    marker_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic          seen_r, seen_nxt;
  logic [CW-1:0] rpos_r, rpos_nxt;
  logic          reading_r, reading_nxt;
  logic          accept;
  logic          match;
  logic [AW-1:0] pos;
  logic [AW-1:0] ridx;
  logic          fin;

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && in_chan.ready;
  assign match = (in_chan.data_byte == marker_r);
  assign pos = AW'(count_r);
  assign ridx = AW'(rpos_r - CW'(1));
  assign fin = (rpos_r >= count_r);

  always_comb begin
    count_nxt = count_r;
    first_nxt = first_r;
    prev_nxt = prev_r;
    seen_nxt = seen_r;
    rpos_nxt = rpos_r;
    reading_nxt = reading_r;
    cmd_valid = 1'b0;
    cmd = '0;
    if (accept) begin
      if (in_chan.opcode == mbs_pkg::OP_PUSH) begin
        if (!reading_r && (count_r < CW'(MAX_PAYLOAD))) begin
          cmd_valid = 1'b1;
          cmd.kind = mbs_pkg::CMD_WRITE;
          cmd.addr = 8'(pos);
          cmd.wdata = in_chan.data_byte;
          cmd.wflag = match;
          cmd.link_we = match && seen_r;
          cmd.link_addr = 8'(prev_r);
          cmd.value = 8'(AW'(pos - prev_r));
          if (match) begin
            if (!seen_r) begin
              first_nxt = 8'(pos);
            end
            prev_nxt = pos;
            seen_nxt = 1'b1;
          end
          count_nxt = count_r + CW'(1);
        end
      end else begin
        cmd_valid = 1'b1;
        if (!reading_r) begin
          cmd.kind = mbs_pkg::CMD_DIRECT;
          cmd.value = first_r;
          cmd.is_overhead = 1'b1;
          cmd.last = (count_r == '0);
          if (count_r == '0) begin
            first_nxt = mbs_pkg::NO_MARKER;
            prev_nxt = '0;
            seen_nxt = 1'b0;
            rpos_nxt = '0;
          end else begin
            reading_nxt = 1'b1;
            rpos_nxt = CW'(1);
          end
        end else begin
          cmd.kind = mbs_pkg::CMD_READ;
          cmd.addr = 8'(ridx);
          cmd.last = fin;
          cmd.last_marker = (ridx == prev_r);
          if (fin) begin
            count_nxt = '0;
            first_nxt = mbs_pkg::NO_MARKER;
            prev_nxt = '0;
            seen_nxt = 1'b0;
            rpos_nxt = '0;
            reading_nxt = 1'b0;
          end else begin
            rpos_nxt = rpos_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= mbs_pkg::MARKER_RESET;
      count_r <= '0;
      first_r <= mbs_pkg::NO_MARKER;
      prev_r <= '0;
      seen_r <= 1'b0;
      rpos_r <= '0;
      reading_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        marker_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      first_r <= first_nxt;
      prev_r <= prev_nxt;
      seen_r <= seen_nxt;
      rpos_r <= rpos_nxt;
      reading_r <= reading_nxt;
    end
  end

endmodule

FILE: sv/mbs_queue.sv
// Two-entry command queue between the front end and the back end.
module mbs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mbs_pkg::mbs_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output mbs_pkg::mbs_cmd_t head_cmd
);

  mbs_pkg::mbs_cmd_t entry_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] fill_r;

  assign full = (fill_r == 2'd2);
  assign head_valid = (fill_r != 2'd0);
  assign head_cmd = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      fill_r <= fill_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: sv/mbs_back.sv
// Back end: payload and link memories, read stage and output register.
module mbs_back #(
  parameter int MAX_PAYLOAD = mbs_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  mbs_pkg::mbs_cmd_t head_cmd,
  output logic              pop,
  mbs_out_if.source         out_chan
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [8:0]    dmem [MAX_PAYLOAD];
  logic [AW-1:0] lmem [MAX_PAYLOAD];

  logic          s1_valid_r;
  logic          s1_direct_r;
  logic [7:0]    s1_value_r;
  logic          s1_ovh_r;
  logic          s1_last_r;
  logic          s1_lastmk_r;
  logic [8:0]    dq_r;
  logic [AW-1:0] lq_r;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_ovh_r;
  logic          out_last_r;

  logic          s1_adv;
  logic          s1_free;
  logic          is_write;
  logic          pop_rd;
  logic [7:0]    s1_byte;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign s1_free = !s1_valid_r || s1_adv;
  assign is_write = (head_cmd.kind == mbs_pkg::CMD_WRITE);
  assign pop = head_valid && (is_write || s1_free);
  assign pop_rd = pop && !is_write;

  always_comb begin
    if (s1_direct_r) begin
      s1_byte = s1_value_r;
    end else if (dq_r[8]) begin
      s1_byte = s1_lastmk_r ? 8'd0 : 8'(lq_r);
    end else begin
      s1_byte = dq_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_write) begin
      dmem[head_cmd.addr[AW-1:0]] <= {head_cmd.wflag, head_cmd.wdata};
      if (head_cmd.link_we) begin
        lmem[head_cmd.link_addr[AW-1:0]] <= head_cmd.value[AW-1:0];
      end
    end
    if (pop_rd && (head_cmd.kind == mbs_pkg::CMD_READ)) begin
      dq_r <= dmem[head_cmd.addr[AW-1:0]];
      lq_r <= lmem[head_cmd.addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop_rd) begin
      case (head_cmd.kind)
        mbs_pkg::CMD_DIRECT: s1_direct_r <= 1'b1;
        default:             s1_direct_r <= 1'b0;
      endcase
      s1_value_r <= head_cmd.value;
      s1_ovh_r <= head_cmd.is_overhead;
      s1_last_r <= head_cmd.last;
      s1_lastmk_r <= head_cmd.last_marker;
    end
    if (s1_adv) begin
      out_byte_r <= s1_byte;
      out_ovh_r <= s1_ovh_r;
      out_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_rd) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.is_overhead = out_ovh_r;
  assign out_chan.last = out_last_r;

endmodule

FILE: sim/tb.sv
// Testbench for the marker byte-stuffing encoder: directed and random push/pull traffic checked beat by beat.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } enc_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_overhead;
    logic       last;
  } enc_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  mbs_in_if  in_chan ();
  mbs_out_if out_chan ();

  marker_byte_stuffing_encoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  enc_beat_t   beat_q[$];
  enc_result_t encoded_q[$];

  logic [7:0] mdl_marker;
  logic [7:0] mdl_store[mbs_pkg::MAX_PAYLOAD_DEF];
  int         mdl_count;
  logic [7:0] mdl_first_pos;
  int         mdl_prev_pos;
  bit         mdl_seen;
  int         mdl_rd_pos;
  bit         mdl_reading;

  int  beats_queued;
  int  beats_taken;
  int  beats_counted;
  int  seq_loaded;
  logic [7:0] seq_marker;
  bit  calm;
  bit  calm_done;
  bit  in_fire;
  int  err_cnt;
  int  cycle_cnt;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got 0x%0h, want 0x%0h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  task automatic clear_packet();
    mdl_count = 0;
    mdl_first_pos = mbs_pkg::NO_MARKER;
    mdl_prev_pos = 0;
    mdl_seen = 1'b0;
    mdl_rd_pos = 0;
    mdl_reading = 1'b0;
  endtask

  task automatic stuff_beat(input logic op, input logic [7:0] d);
    enc_result_t r;
    int idx;
    if (op == mbs_pkg::OP_PUSH) begin
      if (!mdl_reading && mdl_count < mbs_pkg::MAX_PAYLOAD_DEF) begin
        if (d == mdl_marker) begin
          mdl_store[mdl_count] = 8'h00;
          if (mdl_seen) begin
            mdl_store[mdl_prev_pos] = 8'(mdl_count - mdl_prev_pos);
          end else begin
            mdl_first_pos = 8'(mdl_count);
          end
          mdl_prev_pos = mdl_count;
          mdl_seen = 1'b1;
        end else begin
          mdl_store[mdl_count] = d;
        end
        mdl_count++;
      end
    end else if (!mdl_reading) begin
      r.out_byte = mdl_first_pos;
      r.is_overhead = 1'b1;
      r.last = (mdl_count == 0);
      encoded_q.push_back(r);
      if (r.last) begin
        clear_packet();
      end else begin
        mdl_reading = 1'b1;
        mdl_rd_pos = 1;
      end
    end else begin
      idx = mdl_rd_pos - 1;
      r.out_byte = mdl_store[idx];
      r.is_overhead = 1'b0;
      r.last = (mdl_rd_pos >= mdl_count);
      encoded_q.push_back(r);
      if (r.last) begin
        clear_packet();
      end else begin
        mdl_rd_pos++;
      end
    end
  endtask

  // predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin : mon
    enc_result_t w;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end else if (!rst_n) begin
      mdl_marker = mbs_pkg::MARKER_RESET;
      clear_packet();
      in_fire <= 1'b0;
    end else begin
      if (cfg_we) begin
        mdl_marker = cfg_wdata;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (encoded_q.size() == 0) begin
          report_mismatch("unexpected beat", int'(out_chan.out_byte), 0);
        end else begin
          w = encoded_q.pop_front();
          if (out_chan.out_byte !== w.out_byte) begin
            report_mismatch("out_byte", int'(out_chan.out_byte), int'(w.out_byte));
          end
          if (out_chan.is_overhead !== w.is_overhead) begin
            report_mismatch("is_overhead", int'(out_chan.is_overhead), int'(w.is_overhead));
          end
          if (out_chan.last !== w.last) begin
            report_mismatch("last", int'(out_chan.last), int'(w.last));
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        beats_taken++;
        stuff_beat(in_chan.opcode, in_chan.data_byte);
      end
      in_fire <= in_chan.valid && in_chan.ready;
    end
  end

  always @(negedge clk) begin : drv
    enc_beat_t b;
    if (rst_n) begin
      if (!in_chan.valid || in_fire) begin
        if (beat_q.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
          b = beat_q.pop_front();
          in_chan.valid <= 1'b1;
          in_chan.opcode <= b.op;
          in_chan.data_byte <= b.data;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_chan.ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  task automatic queue_beat(input logic op, input logic [7:0] d, input bit counts);
    enc_beat_t b;
    b.op = op;
    b.data = d;
    beat_q.push_back(b);
    beats_queued++;
    if (counts) begin
      beats_counted++;
    end
  endtask

  task automatic wait_idle();
    while (beats_taken != beats_queued || encoded_q.size() != 0) begin
      @(negedge clk);
    end
    // allow a push still in the pipeline to land
    repeat (8) @(negedge clk);
  endtask

  task automatic set_marker(input logic [7:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    seq_marker = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_byte(input logic [7:0] d);
    queue_beat(mbs_pkg::OP_PUSH, d, seq_loaded < mbs_pkg::MAX_PAYLOAD_DEF);
    seq_loaded++;
  endtask

  task automatic load_random();
    if ($urandom_range(99) < 30) begin
      load_byte(seq_marker);
    end else begin
      load_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic drain_packet();
    int pulls;
    pulls = (seq_loaded > mbs_pkg::MAX_PAYLOAD_DEF) ? mbs_pkg::MAX_PAYLOAD_DEF + 1 :
            seq_loaded + 1;
    for (int i = 0; i < pulls; i++) begin
      if (i > 0 && $urandom_range(99) < 15) begin
        queue_beat(mbs_pkg::OP_PUSH, 8'($urandom_range(255)), 1'b0);
      end
      queue_beat(mbs_pkg::OP_PULL, 8'($urandom_range(255)), 1'b1);
    end
    seq_loaded = 0;
  endtask

  function automatic logic [7:0] pick_marker();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return mbs_pkg::MARKER_RESET;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin : seq
    int len;
    int split;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'h00;
    in_chan.valid = 1'b0;
    in_chan.opcode = mbs_pkg::OP_PUSH;
    in_chan.data_byte = 8'h00;
    out_chan.ready = 1'b0;
    seq_marker = mbs_pkg::MARKER_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pull on an empty store
    queue_beat(mbs_pkg::OP_PULL, 8'h00, 1'b1);
    // markers at both ends, push during read-out
    load_byte(mbs_pkg::MARKER_RESET);
    load_byte(8'h00);
    load_byte(8'hFF);
    load_byte(mbs_pkg::MARKER_RESET);
    queue_beat(mbs_pkg::OP_PULL, 8'hFF, 1'b1);
    queue_beat(mbs_pkg::OP_PUSH, mbs_pkg::MARKER_RESET, 1'b0);
    for (int i = 0; i < 4; i++) begin
      queue_beat(mbs_pkg::OP_PULL, 8'h00, 1'b1);
    end
    seq_loaded = 0;
    // extreme markers, changed in the middle of a load
    set_marker(8'h00);
    load_byte(8'h00);
    load_byte(8'hFF);
    load_byte(8'h00);
    set_marker(8'hFF);
    load_byte(8'hFF);
    load_byte(8'h80);
    drain_packet();

    // full store plus dropped pushes
    set_marker(mbs_pkg::MARKER_RESET);
    for (int i = 0; i < mbs_pkg::MAX_PAYLOAD_DEF + 3; i++) begin
      load_random();
    end
    drain_packet();

    while (beats_counted < 1030) begin
      if (!calm && !calm_done && beats_counted >= 650) begin
        wait_idle();
        calm = 1'b1;
      end
      if (!calm && $urandom_range(5) == 0) begin
        set_marker(pick_marker());
      end
      len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 24);
      split = (!calm && $urandom_range(9) == 0) ? $urandom_range(0, len) : -1;
      for (int i = 0; i < len; i++) begin
        if (i == split) begin
          set_marker(pick_marker());
        end
        load_random();
      end
      drain_packet();
      if (calm && beats_counted >= 800) begin
        wait_idle();
        calm = 1'b0;
        calm_done = 1'b1;
      end
    end
    calm = 1'b0;

    wait_idle();
    if (encoded_q.size() != 0) begin
      report_mismatch("results never seen", encoded_q.size(), 0);
    end
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mbs_pkg.sv
sv/mbs_if.sv
sv/mbs_front.sv
sv/mbs_queue.sv
sv/mbs_back.sv
sv/marker_byte_stuffing_encoder_core.sv
sim/tb.sv
